// ===== src/mamt_pkg.sv =====
// shared constants, types and helpers for the moving average tracker
`timescale 1ns / 1ps

package mamt_pkg;

  localparam int RING_DEPTH   = 8;
  localparam int SAMPLE_BITS  = 16;
  localparam int WIN_BITS     = 4;
  localparam int WINDOW_RESET = 4;
  localparam int PTR_BITS     = $clog2(RING_DEPTH);
  localparam int CNT_BITS     = $clog2(RING_DEPTH + 1);
  // one guard bit so the magnitude of the most negative sum still fits
  localparam int SUM_BITS     = SAMPLE_BITS + PTR_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic [PTR_BITS-1:0]           ptr_t;
  typedef logic [CNT_BITS-1:0]           cnt_t;
  typedef logic [WIN_BITS-1:0]           win_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic    we;
    ptr_t    waddr;
    sample_t wdata;
    logic    re;
    ptr_t    raddr;
  } ram_req_t;

  typedef struct packed {
    logic start;
    sum_t dividend;
    cnt_t divisor;
  } div_req_t;

  typedef struct packed {
    logic    done;
    sample_t quotient;
  } div_rsp_t;

  // zero counts as one, anything past the ring depth is clamped
  function automatic cnt_t span_of(win_t w);
    cnt_t s;
    if (w == '0) begin
      s = cnt_t'(1);
    end else if (int'(w) > RING_DEPTH) begin
      s = cnt_t'(RING_DEPTH);
    end else begin
      s = cnt_t'(w);
    end
    return s;
  endfunction

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == ptr_t'(RING_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t ptr_dec(ptr_t p);
    return (p == '0) ? ptr_t'(RING_DEPTH - 1) : p - ptr_t'(1);
  endfunction

endpackage

// ===== src/mamt_if.sv =====
// valid/ready channel interfaces for sample input and result output
`timescale 1ns / 1ps

interface mamt_in_if import mamt_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mamt_out_if import mamt_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t max_seen;
  sample_t min_seen;
  sample_t average;
  logic    average_valid;

  modport source (output valid, output max_seen, output min_seen, output average,
                  output average_valid, input ready);
  modport sink (input valid, input max_seen, input min_seen, input average,
                input average_valid, output ready);
endinterface

// ===== src/mamt_ring_ram.sv =====
// sample ring memory, one write and one registered read port
`timescale 1ns / 1ps

module mamt_ring_ram import mamt_pkg::*; (
  input  logic     clk_i,
  input  ram_req_t req_i,
  output sample_t  rdata_o
);

  sample_t mem [RING_DEPTH];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mamt_div.sv =====
// serial restoring divider, signed sum over unsigned span, one quotient bit per cycle
`timescale 1ns / 1ps

module mamt_div import mamt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [SUM_BITS-1:0]     quo_q, quo_d;
  cnt_t                    rem_q, rem_d;
  cnt_t                    dvs_q, dvs_d;
  logic                    neg_q, neg_d;

  logic [CNT_BITS:0]   rem_sh;
  logic [CNT_BITS:0]   rem_sub;
  logic                fits;
  logic [SUM_BITS-1:0] mag;
  logic [SUM_BITS-1:0] quo_signed;

  always_comb begin
    rem_sh  = {rem_q, quo_q[SUM_BITS-1]};
    fits    = (rem_sh >= {1'b0, dvs_q});
    rem_sub = rem_sh - {1'b0, dvs_q};
    mag     = req_i.dividend[SUM_BITS-1] ? unsigned'(-req_i.dividend)
                                         : unsigned'(req_i.dividend);

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = mag;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      neg_d  = req_i.dividend[SUM_BITS-1];
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
      quo_d = {quo_q[SUM_BITS-2:0], fits};
      cnt_d = cnt_q + DIV_CNT_BITS'(1);
      if (cnt_q == DIV_CNT_BITS'(SUM_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  // truncation toward zero falls out of dividing the magnitude
  assign quo_signed     = neg_q ? (~quo_q + SUM_BITS'(1)) : quo_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = sample_t'(quo_signed[SAMPLE_BITS-1:0]);

endmodule

// ===== src/moving_average_min_max_tracker_top.sv =====
// Moving average with running min and max. Each input beat carries one signed
// sample; it is written to an eight-entry ring memory while the running max and min
// are updated (the first sample after reset sets both). When at least window
// samples are held, the older window-1 entries are read back one per cycle and
// added to the new sample, then a serial divider produces the mean, truncated
// toward zero, one quotient bit per cycle over the 20-bit sum. An item that forms
// a mean passes through the read-back, the divider and the output register before
// its result shows; one that does not goes straight to the output register. A
// result beat still waiting in the output register keeps the new result, and with
// it the next sample, waiting. One item is in work at a time; a finished result
// waits in the output register while the next sample is taken. The window
// register (reset 4, zero read as 1, values past the ring depth clamped) should
// only be written while the block is idle.
`timescale 1ns / 1ps

module moving_average_min_max_tracker_top import mamt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  win_t       cfg_wdata_i,
  mamt_in_if.sink    in_i,
  mamt_out_if.source out_o
);

  state_e state_q, state_d;

  win_t    window_q, window_d;
  ptr_t    wr_ptr_q, wr_ptr_d;
  ptr_t    rd_ptr_q, rd_ptr_d;
  cnt_t    fill_q, fill_d;
  cnt_t    span_q, span_d;
  cnt_t    issue_left_q, issue_left_d;
  cnt_t    recv_left_q, recv_left_d;
  logic    rd_pend_q, rd_pend_d;
  sum_t    acc_q, acc_d;
  sample_t max_q, max_d;
  sample_t min_q, min_d;
  sample_t avg_q, avg_d;
  logic    avg_rdy_q, avg_rdy_d;

  logic    out_valid_q, out_valid_d;
  sample_t out_max_q, out_max_d;
  sample_t out_min_q, out_min_d;
  sample_t out_avg_q, out_avg_d;
  logic    out_avg_vld_q, out_avg_vld_d;

  logic     accept;
  logic     out_load;
  cnt_t     span_now;
  cnt_t     fill_inc;
  logic     reach;
  ram_req_t ram_req;
  sample_t  ram_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;

  mamt_ring_ram u_ring_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  mamt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    span_now = span_of(window_q);
    fill_inc = (fill_q == cnt_t'(RING_DEPTH)) ? fill_q : fill_q + cnt_t'(1);
    reach    = (fill_inc >= span_now);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = reach ? ST_SUM : ST_OUT;
        end
      end
      ST_SUM: begin
        if (recv_left_q == '0) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_i.ready       = 1'b0;
    out_load         = 1'b0;
    ram_req.re       = 1'b0;
    div_req.start    = 1'b0;
    case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_SUM: begin
        ram_req.re    = (issue_left_q != '0);
        div_req.start = (recv_left_q == '0);
      end
      ST_DIV: ;
      ST_OUT: out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
    accept          = in_i.valid && in_i.ready;
    // the new sample is written at accept, reads of older entries follow later
    ram_req.we      = accept;
    ram_req.waddr   = wr_ptr_q;
    ram_req.wdata   = in_i.sample;
    ram_req.raddr   = rd_ptr_q;
    div_req.dividend = acc_q;
    div_req.divisor  = span_q;
  end

  // datapath
  always_comb begin
    window_d      = cfg_we_i ? cfg_wdata_i : window_q;
    wr_ptr_d      = wr_ptr_q;
    rd_ptr_d      = rd_ptr_q;
    fill_d        = fill_q;
    span_d        = span_q;
    issue_left_d  = issue_left_q;
    recv_left_d   = recv_left_q;
    rd_pend_d     = ram_req.re;
    acc_d         = acc_q;
    max_d         = max_q;
    min_d         = min_q;
    avg_d         = avg_q;
    avg_rdy_d     = avg_rdy_q;
    out_valid_d   = out_valid_q;
    out_max_d     = out_max_q;
    out_min_d     = out_min_q;
    out_avg_d     = out_avg_q;
    out_avg_vld_d = out_avg_vld_q;

    if (accept) begin
      if (fill_q == '0) begin
        max_d = in_i.sample;
        min_d = in_i.sample;
      end else begin
        if (in_i.sample > max_q) max_d = in_i.sample;
        if (in_i.sample < min_q) min_d = in_i.sample;
      end
      wr_ptr_d     = ptr_inc(wr_ptr_q);
      rd_ptr_d     = ptr_dec(wr_ptr_q);
      fill_d       = fill_inc;
      span_d       = span_now;
      avg_rdy_d    = reach;
      acc_d        = sum_t'(in_i.sample);
      issue_left_d = span_now - cnt_t'(1);
      recv_left_d  = span_now - cnt_t'(1);
    end

    if (ram_req.re) begin
      rd_ptr_d     = ptr_dec(rd_ptr_q);
      issue_left_d = issue_left_q - cnt_t'(1);
    end

    if (rd_pend_q) begin
      acc_d       = acc_q + sum_t'(ram_rdata);
      recv_left_d = recv_left_q - cnt_t'(1);
    end

    if (state_q == ST_DIV && div_rsp.done) begin
      avg_d = div_rsp.quotient;
    end

    if (out_load) begin
      out_valid_d   = 1'b1;
      out_max_d     = max_q;
      out_min_d     = min_q;
      out_avg_d     = avg_q;
      out_avg_vld_d = avg_rdy_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= win_t'(WINDOW_RESET);
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      rd_pend_q   <= 1'b0;
      max_q       <= '0;
      min_q       <= '0;
      avg_q       <= '0;
      avg_rdy_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      window_q    <= window_d;
      wr_ptr_q    <= wr_ptr_d;
      fill_q      <= fill_d;
      rd_pend_q   <= rd_pend_d;
      max_q       <= max_d;
      min_q       <= min_d;
      avg_q       <= avg_d;
      avg_rdy_q   <= avg_rdy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q      <= rd_ptr_d;
    span_q        <= span_d;
    issue_left_q  <= issue_left_d;
    recv_left_q   <= recv_left_d;
    acc_q         <= acc_d;
    out_max_q     <= out_max_d;
    out_min_q     <= out_min_d;
    out_avg_q     <= out_avg_d;
    out_avg_vld_q <= out_avg_vld_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.max_seen      = out_max_q;
  assign out_o.min_seen      = out_min_q;
  assign out_o.average       = out_avg_q;
  assign out_o.average_valid = out_avg_vld_q;

endmodule

// ===== src/mamt_checker.sv =====
// port-level assertions for the moving average tracker, bound to the top level
`timescale 1ns / 1ps

module mamt_checker import mamt_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input sample_t max_seen_i,
  input sample_t min_seen_i,
  input sample_t average_i,
  input logic    average_valid_i
);

  // a result beat stays offered until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped before it was taken");

  a_max_ge_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> max_seen_i >= min_seen_i)
    else $error("max below min");

  // a fresh mean lies within the extremes seen so far
  a_avg_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && average_valid_i |-> average_i <= max_seen_i && average_i >= min_seen_i)
    else $error("average outside max/min range");

  // one sample in work at a time
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample taken while the previous one is in work");

endmodule

bind moving_average_min_max_tracker_top mamt_checker u_mamt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .max_seen_i      (out_o.max_seen),
  .min_seen_i      (out_o.min_seen),
  .average_i       (out_o.average),
  .average_valid_i (out_o.average_valid)
);

// ===== tb/sv/mamt_result_checker.sv =====
// result checker for the moving average tracker: tracks accepted samples and compares each result beat
`timescale 1ns / 1ps

module mamt_result_checker import mamt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  win_t cfg_wdata_i,
  mamt_in_if   in_mon,
  mamt_out_if  out_mon,
  output int   mismatches_o,
  output int   pending_o
);

  typedef struct packed {
    sample_t peak;
    sample_t trough;
    sample_t mean;
    logic    mean_ok;
  } reading_t;

  reading_t expected_readings[$];

  // own copy of the tracker state
  sample_t history [RING_DEPTH];
  ptr_t    next_slot;
  cnt_t    held;
  sample_t peak;
  sample_t trough;
  sample_t mean;
  logic    mean_ok;
  win_t    window;
  int      mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic track_sample(input sample_t s);
    reading_t r;
    int       span;
    int       total;
    int       pos;
    if (held == '0) begin
      peak   = s;
      trough = s;
    end else begin
      if (s > peak) begin
        peak = s;
      end
      if (s < trough) begin
        trough = s;
      end
    end
    history[next_slot] = s;
    next_slot = ptr_t'((int'(next_slot) + 1) % RING_DEPTH);
    if (int'(held) < RING_DEPTH) begin
      held = held + cnt_t'(1);
    end
    // zero acts as one, anything past the ring is clamped
    if (window == '0) begin
      span = 1;
    end else if (int'(window) > RING_DEPTH) begin
      span = RING_DEPTH;
    end else begin
      span = int'(window);
    end
    if (int'(held) >= span) begin
      total = 0;
      pos = int'(next_slot);
      for (int k = 0; k < span; k++) begin
        pos = (pos + RING_DEPTH - 1) % RING_DEPTH;
        total += int'(history[pos]);
      end
      // int division truncates toward zero
      mean = sample_t'(total / span);
      mean_ok = 1'b1;
    end else begin
      mean_ok = 1'b0;
    end
    r.peak    = peak;
    r.trough  = trough;
    r.mean    = mean;
    r.mean_ok = mean_ok;
    expected_readings.push_back(r);
  endtask

  task automatic check_reading();
    reading_t want;
    if (expected_readings.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result beat: max %0d min %0d avg %0d valid %0b",
                 out_mon.max_seen, out_mon.min_seen, out_mon.average, out_mon.average_valid);
      end
    end else begin
      want = expected_readings.pop_front();
      if (out_mon.max_seen !== want.peak || out_mon.min_seen !== want.trough ||
          out_mon.average !== want.mean || out_mon.average_valid !== want.mean_ok) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result beat mismatch: expected max %0d min %0d avg %0d valid %0b",
                   want.peak, want.trough, want.mean, want.mean_ok);
          $display("                      got      max %0d min %0d avg %0d valid %0b",
                   out_mon.max_seen, out_mon.min_seen, out_mon.average,
                   out_mon.average_valid);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_readings.delete();
      foreach (history[i]) begin
        history[i] = '0;
      end
      next_slot = '0;
      held      = '0;
      peak      = '0;
      trough    = '0;
      mean      = '0;
      mean_ok   = 1'b0;
      window    = win_t'(WINDOW_RESET);
      pending_o <= 0;
    end else begin
      // results first: a beat leaving now never belongs to the sample entering now
      if (out_mon.valid && out_mon.ready) begin
        check_reading();
      end
      if (in_mon.valid && in_mon.ready) begin
        track_sample(in_mon.sample);
      end
      if (cfg_we_i) begin
        window = cfg_wdata_i;
      end
      pending_o <= expected_readings.size();
    end
  end

endmodule

// ===== tb/sv/moving_average_min_max_tracker_top_test.sv =====
// testbench top for the moving average tracker: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps

module moving_average_min_max_tracker_top_test;
  import mamt_pkg::*;

  localparam int      QUIET_LIMIT = 5000;
  localparam int      HOLD_CYCLES = 300;
  localparam int      TAIL_CYCLES = 40;
  localparam int      BLOCKS      = 20;
  localparam int      BLOCK_ITEMS = 50;
  localparam sample_t SAMPLE_HI   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_LO   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  win_t cfg_wdata_i;

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int mismatches;
  int pending;

  mamt_in_if  in_if ();
  mamt_out_if out_if ();

  moving_average_min_max_tracker_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  mamt_result_checker results (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // result side: random stalls, or a long hold-off while hold_left counts down
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
  endtask

  // one edge first so the beat just accepted is already counted as pending
  task automatic wait_results_in();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_window(input win_t w);
    wait_results_in();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(19))
      0:       return SAMPLE_HI;
      1:       return SAMPLE_LO;
      2, 3, 4: return sample_t'(int'($urandom_range(600)) - 300);
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    win_t next_window;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window of 4: no mean yet, first sample sets both max and min
    send_sample(sample_t'(-500));
    send_sample(sample_t'(1200));
    set_window(win_t'(1));
    send_sample(sample_t'(-7));
    // window now wider than what is held: last mean held, flagged not valid
    set_window(win_t'(8));
    send_sample(sample_t'(0));
    send_sample(sample_t'(-1));
    // past the ring depth, clamped to 8
    set_window(win_t'(15));
    send_sample(SAMPLE_HI);
    send_sample(SAMPLE_LO);
    send_sample(SAMPLE_LO);
    // zero window acts as one
    set_window(win_t'(0));
    send_sample(sample_t'(16'h5555));
    send_sample(sample_t'(16'haaaa));
    // truncation toward zero on negative sums
    set_window(win_t'(3));
    send_sample(SAMPLE_LO);
    send_sample(SAMPLE_LO);
    send_sample(SAMPLE_LO);
    send_sample(SAMPLE_HI);
    send_sample(sample_t'(-4));

    for (int blk = 0; blk < BLOCKS; blk++) begin
      case (blk)
        0:       next_window = win_t'(1);
        1:       next_window = win_t'(RING_DEPTH);
        2:       next_window = '0;
        3:       next_window = '1;
        default: next_window = win_t'($urandom_range(15));
      endcase
      set_window(next_window);
      case (blk % 4)
        0: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
        1: begin
          send_gap_pct = 78;
          stall_pct    = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct    = 78;
        end
        default: begin
          send_gap_pct = 36;
          stall_pct    = 36;
        end
      endcase
      // result side held off while samples keep coming, so the input backs up
      if (blk == 4) begin
        hold_left = HOLD_CYCLES;
      end
      repeat (BLOCK_ITEMS) send_sample(pick_sample());
    end

    wait_results_in();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
